// ----- rtl/core/bsa_pkg.sv -----
// Shared types, constants and helpers for the bitmap slot allocator.
package bsa_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned MaxWords  = 32;
  localparam int unsigned AddrW     = $clog2(MaxWords);
  localparam int unsigned OffW      = $clog2(WordBits);
  localparam int unsigned SlotW     = 10;
  localparam int unsigned CfgW      = 6;
  localparam int unsigned WordCntW  = AddrW + 1;

  typedef enum logic [1:0] {
    KindTest = 2'd0,
    KindFind = 2'd1,
    KindMark = 2'd2,
    KindFree = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone  = 3'd0,
    ErrRange = 3'd1,
    ErrUsed  = 3'd2,
    ErrFree  = 3'd3,
    ErrFull  = 3'd4
  } err_e;

  typedef enum logic {
    StIdle,
    StWork
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [SlotW-1:0]  bit_index;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              bit_value;
    logic [SlotW-1:0]  found_index;
    err_e              error;
  } rsp_t;

  typedef struct packed {
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [WordBits-1:0] wr_data;
  } mem_req_t;

  // lowest clear bit of a word; 0 when the word is all ones
  function automatic logic [OffW-1:0] lowest_zero(input logic [WordBits-1:0] w);
    logic [OffW-1:0] pos;
    pos = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (!w[k]) begin
        pos = OffW'(k);
      end
    end
    return pos;
  endfunction

endpackage

// ----- rtl/core/bitmap_slot_allocator.sv -----
// Test/mark/free read the addressed bitmap word, then retire into the result register.
// Find scans one bitmap word per cycle, up to words_in_use words (capped at 32).
// One request at a time; the next beat is taken the cycle after retiring.
// Reset: map reads all free at once (per-word valid bits), words_in_use=32.
// Top level of the bitmap slot allocator.
module bitmap_slot_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsa_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bsa_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bsa_pkg::rsp_t                out_data_o
);
  import bsa_pkg::*;

  logic [CfgW-1:0]     words_q;
  logic [WordCntW-1:0] nwords;
  mem_req_t            mem_req;
  logic [WordBits-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= CfgW'(MaxWords);
    end else if (cfg_we_i) begin
      words_q <= cfg_wdata_i;
    end
  end

  assign nwords = (words_q > CfgW'(MaxWords)) ? WordCntW'(MaxWords) : WordCntW'(words_q);

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nwords_i    (nwords),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  bsa_map_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready while a request is in flight");

  a_ok_matches_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ok == (out_data_o.error == ErrNone)))
    else $error("ok flag disagrees with error code");

  a_bitval_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bit_value |-> out_data_o.ok)
    else $error("bit value set on a failed request");

  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> !mem_req.rd_en && !in_ready_o)
    else $error("map write overlaps a read or idle state");
`endif

endmodule

// ----- rtl/core/bsa_map_mem.sv -----
// Bitmap word store with per-word valid bits and a registered read port.
module bsa_map_mem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsa_pkg::mem_req_t               req_i,
  output logic [bsa_pkg::WordBits-1:0]    rd_data_o
);
  import bsa_pkg::*;

  logic [WordBits-1:0] mem [MaxWords];
  logic [MaxWords-1:0] valid_q;
  logic [WordBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_data_q <= '0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_data_q <= valid_q[req_i.rd_addr] ? mem[req_i.rd_addr] : '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/bsa_ctrl.sv -----
// Request sequencer: word scan, slot test/mark/free and the result register.
module bsa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bsa_pkg::WordCntW-1:0]   nwords_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bsa_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bsa_pkg::rsp_t                  out_data_o,
  output bsa_pkg::mem_req_t              mem_req_o,
  input  logic [bsa_pkg::WordBits-1:0]   rd_data_i
);
  import bsa_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [AddrW-1:0]  word_q, word_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              done;
  rsp_t              res;
  logic              used;
  logic [WordBits-1:0] mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    word_q <= word_d;
    out_q  <= out_d;
  end

  assign mask = WordBits'(1) << req_q.bit_index[OffW-1:0];
  assign used = (rd_data_i & mask) != '0;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_req_o   = '0;
    done        = 1'b0;
    res         = '0;
    res.error   = ErrNone;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d             = in_data_i;
          word_d            = '0;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = (in_data_i.kind == KindFind) ?
                              '0 : in_data_i.bit_index[SlotW-1:OffW];
          state_d           = StWork;
        end
      end
      StWork: begin
        if (req_q.kind == KindFind) begin
          if (nwords_i == '0) begin
            res.error = ErrFull;
            done      = 1'b1;
          end else if (rd_data_i != '1) begin
            res.ok          = 1'b1;
            res.found_index = {word_q, lowest_zero(rd_data_i)};
            done            = 1'b1;
          end else if ({1'b0, word_q} + WordCntW'(1) >= nwords_i) begin
            res.error = ErrFull;
            done      = 1'b1;
          end else begin
            word_d            = word_q + AddrW'(1);
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = word_q + AddrW'(1);
          end
        end else begin
          done = 1'b1;
          if ({1'b0, req_q.bit_index} >= {nwords_i, {OffW{1'b0}}}) begin
            res.error = ErrRange;
          end else begin
            case (req_q.kind)
              KindTest: begin
                res.ok        = 1'b1;
                res.bit_value = used;
              end
              KindMark: begin
                if (used) begin
                  res.error = ErrUsed;
                end else begin
                  res.ok            = 1'b1;
                  mem_req_o.wr_data = rd_data_i | mask;
                end
              end
              default: begin
                if (!used) begin
                  res.error = ErrFree;
                end else begin
                  res.ok            = 1'b1;
                  mem_req_o.wr_data = rd_data_i & ~mask;
                end
              end
            endcase
          end
        end
        // retire only when the result register is free; read data holds meanwhile
        if (done && (!out_valid_q || out_ready_i)) begin
          out_valid_d       = 1'b1;
          out_d             = res;
          mem_req_o.wr_en   = res.ok && (req_q.kind == KindMark || req_q.kind == KindFree);
          mem_req_o.wr_addr = req_q.bit_index[SlotW-1:OffW];
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
